/* src/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Implication that also holds through reset.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("unconditional check failed");

`endif

/* src/cbd_pkg.sv */
package cbd_pkg;

  // Configuration register width and reset value
  localparam int CFG_W = 26;
  localparam logic [CFG_W-1:0] MAX_BODY_RESET = CFG_W'(32 * 1024 * 1024);

  // Default width of chunk size and total counters
  localparam int LEN_BITS_DEFAULT = 26;

  // Hex digit width and radix
  localparam int HEX_W = 4;
  localparam int RADIX = 16;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  // Line terminator and separator characters
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  // Parser phases, one-hot
  typedef enum logic [12:0] {
    PH_IDLE        = 13'b0000000000001,
    PH_SIZE        = 13'b0000000000010,
    PH_SIZE_LF     = 13'b0000000000100,
    PH_EXT         = 13'b0000000001000,
    PH_EXT_LF      = 13'b0000000010000,
    PH_DATA        = 13'b0000000100000,
    PH_DATA_CR     = 13'b0000001000000,
    PH_DATA_LF     = 13'b0000010000000,
    PH_TR_FIRST    = 13'b0000100000000,
    PH_TR_FIRST_LF = 13'b0001000000000,
    PH_TRAILER     = 13'b0010000000000,
    PH_DONE        = 13'b0100000000000,
    PH_FAIL        = 13'b1000000000000
  } phase_t;

  typedef struct packed {
    logic             valid;
    logic [HEX_W-1:0] value;
  } hex_digit_t;

  // Decode one ASCII hex digit
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.valid = 1'b0;
    r.value = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r.valid = 1'b1;
      r.value = HEX_W'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      r.valid = 1'b1;
      r.value = HEX_W'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      r.valid = 1'b1;
      r.value = HEX_W'(c - 8'h37);
    end
    return r;
  endfunction

endpackage

/* src/chunked_body_decoder_unit.sv */
// Chunked body decoder: takes one raw byte of a chunked message body per word on the
// input channel and gives at most one result word per input: a payload byte, body complete,
// or malformed (flagged at the offending byte). A word with new_body high restarts the
// parser and is itself parsed as the first byte. Throughput is one byte per clock. A byte's
// result is loaded into the output register at the edge that accepts the byte and is
// offered from the next cycle on. A new byte is taken in any cycle in which that register
// is empty or being read, so a stalled result holds off the input. The critical path is the
// size digit update: a LEN_BITS+4 bit shift-add, an add of the decoded total and a compare
// against the limit (the smaller of max_body and 2^LEN_BITS - 1). After a result of complete
// or malformed, bytes give nothing until new_body. max_body must be written only while no
// body is in progress; the block itself does not enforce this.
module chunked_body_decoder_unit
  import cbd_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  // byte input
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             new_body,
  // result output
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       result_kind,
  output logic [7:0]       payload_byte,
  // max_body write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  // Wide enough for size*16 + digit + total and for the limit
  localparam int BASE_W = (LEN_BITS > CFG_W) ? LEN_BITS : CFG_W;
  localparam int SUM_W  = BASE_W + HEX_W + 1;
  localparam int SIZE_W = LEN_BITS + HEX_W;

  logic [CFG_W-1:0]    max_body;
  phase_t              phase, phase_next;
  logic [LEN_BITS-1:0] chunk_remaining, chunk_next;
  logic [LEN_BITS-1:0] body_total, total_next;
  logic                size_has_digit, has_digit_next;
  logic [1:0]          trailer_match, match_next;

  logic                emit;
  logic [1:0]          kind;
  logic                in_fire;

  // Restart-adjusted view of the state
  phase_t              ph_cur;
  logic [LEN_BITS-1:0] chunk_cur, total_cur;
  logic                digit_cur;
  logic [1:0]          match_cur;

  hex_digit_t          hex;
  logic [SIZE_W-1:0]   size_shifted;
  logic [SUM_W-1:0]    size_sum, limit, max_w, mask_w;
  logic [7:0]          want;

  assign in_ready  = !rst && (!out_valid || out_ready);
  assign cfg_ready = !rst;
  assign in_fire   = in_valid && in_ready;

  // Limit in use: smaller of max_body and the counter range
  assign max_w  = SUM_W'(max_body);
  assign mask_w = {{(SUM_W-LEN_BITS){1'b0}}, {LEN_BITS{1'b1}}};
  assign limit  = (max_w < mask_w) ? max_w : mask_w;

  assign hex          = hex_decode(data_byte);
  assign size_shifted = {chunk_cur, {HEX_W{1'b0}}} | SIZE_W'(hex.value);
  assign size_sum     = SUM_W'(size_shifted) + SUM_W'(total_cur);
  assign want         = trailer_match[0] ? CHAR_LF : CHAR_CR;

  // Next state and result for one byte
  always_comb begin
    ph_cur    = new_body ? PH_SIZE : phase;
    chunk_cur = new_body ? '0 : chunk_remaining;
    total_cur = new_body ? '0 : body_total;
    digit_cur = new_body ? 1'b0 : size_has_digit;
    match_cur = new_body ? 2'd0 : trailer_match;

    phase_next     = ph_cur;
    chunk_next     = chunk_cur;
    total_next     = total_cur;
    has_digit_next = digit_cur;
    match_next     = match_cur;
    emit           = 1'b0;
    kind           = KIND_PAYLOAD;

    case (ph_cur)
      PH_SIZE: begin
        if (hex.valid) begin
          if (size_sum > limit) begin
            emit       = 1'b1;
            kind       = KIND_BAD;
            phase_next = PH_FAIL;
          end else begin
            chunk_next     = LEN_BITS'(size_shifted);
            has_digit_next = 1'b1;
          end
        end else if (!digit_cur) begin
          emit       = 1'b1;
          kind       = KIND_BAD;
          phase_next = PH_FAIL;
        end else if (data_byte == CHAR_SEMI) begin
          phase_next = PH_EXT;
        end else if (data_byte == CHAR_CR) begin
          phase_next = PH_SIZE_LF;
        end else begin
          emit       = 1'b1;
          kind       = KIND_BAD;
          phase_next = PH_FAIL;
        end
      end
      PH_SIZE_LF, PH_EXT_LF: begin
        if (data_byte == CHAR_LF) begin
          // size line done
          if (chunk_cur == '0) begin
            phase_next = PH_TR_FIRST;
          end else begin
            total_next = total_cur + chunk_cur;
            phase_next = PH_DATA;
          end
        end else if (ph_cur == PH_SIZE_LF) begin
          emit       = 1'b1;
          kind       = KIND_BAD;
          phase_next = PH_FAIL;
        end else if (data_byte != CHAR_CR) begin
          phase_next = PH_EXT;
        end
      end
      PH_EXT: begin
        if (data_byte == CHAR_CR) phase_next = PH_EXT_LF;
      end
      PH_DATA: begin
        chunk_next = chunk_cur - LEN_BITS'(1);
        emit       = 1'b1;
        kind       = KIND_PAYLOAD;
        if (chunk_cur == LEN_BITS'(1)) phase_next = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (data_byte != CHAR_CR) begin
          emit       = 1'b1;
          kind       = KIND_BAD;
          phase_next = PH_FAIL;
        end else begin
          phase_next = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (data_byte != CHAR_LF) begin
          emit       = 1'b1;
          kind       = KIND_BAD;
          phase_next = PH_FAIL;
        end else begin
          phase_next     = PH_SIZE;
          chunk_next     = '0;
          has_digit_next = 1'b0;
        end
      end
      PH_TR_FIRST: begin
        if (data_byte == CHAR_CR) begin
          phase_next = PH_TR_FIRST_LF;
        end else begin
          match_next = 2'd0;
          phase_next = PH_TRAILER;
        end
      end
      PH_TR_FIRST_LF: begin
        if (data_byte == CHAR_LF) begin
          emit       = 1'b1;
          kind       = KIND_DONE;
          phase_next = PH_DONE;
        end else begin
          match_next = (data_byte == CHAR_CR) ? 2'd1 : 2'd0;
          phase_next = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        // look for CR LF CR LF
        if (data_byte == want) begin
          if (match_cur == 2'd3) begin
            match_next = 2'd0;
            emit       = 1'b1;
            kind       = KIND_DONE;
            phase_next = PH_DONE;
          end else begin
            match_next = match_cur + 2'd1;
          end
        end else begin
          match_next = (data_byte == CHAR_CR) ? 2'd1 : 2'd0;
        end
      end
      default: begin
        // idle, done or failed: byte is dropped
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      chunk_remaining <= '0;
      body_total      <= '0;
      size_has_digit  <= 1'b0;
      trailer_match   <= 2'd0;
    end else if (in_fire) begin
      phase           <= phase_next;
      chunk_remaining <= chunk_next;
      body_total      <= total_next;
      size_has_digit  <= has_digit_next;
      trailer_match   <= match_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_body <= MAX_BODY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_body <= cfg_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      result_kind  <= kind;
      payload_byte <= (kind == KIND_PAYLOAD) ? data_byte : 8'h00;
    end
  end

endmodule

/* src/cbd_checker.sv */
`include "assert_macros.svh"

module cbd_checker
  import cbd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [7:0]       data_byte,
  input logic             new_body,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       result_kind,
  input logic [7:0]       payload_byte,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [CFG_W-1:0] cfg_data
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  // A stalled result word holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid && $stable({result_kind, payload_byte}))

  // Only defined result kinds leave the block (bad is the highest code)
  `ASSERT_IMPLY(a_kind_legal, clk, rst, out_valid, result_kind <= KIND_BAD)

  // Status words carry a zero byte
  `ASSERT_IMPLY(a_status_zero, clk, rst, out_valid && result_kind != KIND_PAYLOAD, payload_byte == 8'h00)

  // No new byte while a result is stuck in the output register
  `ASSERT_IMPLY(a_no_overrun, clk, rst, out_stall, !in_ready)

  // Output register is empty on the first edge after reset
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) && !rst, !out_valid)

endmodule

bind chunked_body_decoder_unit cbd_checker u_cbd_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import cbd_pkg::*;

  localparam longint unsigned LEN_MASK = (64'd1 << LEN_BITS_DEFAULT) - 64'd1;
  localparam int STUCK_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DIRECTED_CFG_AT = 18;

  // how a stimulus word's result is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_WORD
  } check_mode_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    check_mode_t mode;
    logic [1:0]  kind;
    logic [7:0]  pbyte;
  } stim_row_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pbyte;
  } result_word_t;

  // Directed words; max_body drops to zero before row DIRECTED_CFG_AT
  localparam stim_row_t DIRECTED [29] = '{
    '{8'hFF,     1'b0, CHK_NONE,  KIND_PAYLOAD, 8'h00},  // no body open yet
    '{"1",       1'b1, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{CHAR_CR,   1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{CHAR_LF,   1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{8'h00,     1'b0, CHK_WORD,  KIND_PAYLOAD, 8'h00},
    '{CHAR_CR,   1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{CHAR_LF,   1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{"0",       1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{CHAR_CR,   1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{CHAR_LF,   1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{CHAR_CR,   1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{CHAR_LF,   1'b0, CHK_WORD,  KIND_DONE,    8'h00},  // empty trailer
    '{"A",       1'b0, CHK_NONE,  KIND_PAYLOAD, 8'h00},  // after complete
    '{CHAR_SEMI, 1'b1, CHK_WORD,  KIND_BAD,     8'h00},  // size with no digit
    '{"g",       1'b1, CHK_WORD,  KIND_BAD,     8'h00},  // non-hex size char
    '{"2",       1'b1, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{CHAR_CR,   1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{"x",       1'b0, CHK_WORD,  KIND_BAD,     8'h00},  // CR without LF
    '{"f",       1'b1, CHK_WORD,  KIND_BAD,     8'h00},  // size over zero limit
    '{"0",       1'b1, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{CHAR_SEMI, 1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{8'hFF,     1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},  // extension byte
    '{CHAR_CR,   1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{CHAR_LF,   1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{"T",       1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{CHAR_CR,   1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{CHAR_LF,   1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{CHAR_CR,   1'b0, CHK_MODEL, KIND_PAYLOAD, 8'h00},
    '{CHAR_LF,   1'b0, CHK_WORD,  KIND_DONE,    8'h00}   // trailer closed
  };

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       data_byte = 8'h00;
  logic             new_body = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       result_kind;
  logic [7:0]       payload_byte;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  // check mode of the word currently offered, moves with the payload
  check_mode_t tag_mode = CHK_MODEL;
  logic [1:0]  tag_kind = KIND_PAYLOAD;
  logic [7:0]  tag_byte = 8'h00;

  // decoder shadow state
  phase_t           ps;
  logic [25:0]      chunk_left;
  logic [25:0]      body_sum;
  bit               too_large;
  bit               has_digit;
  logic [1:0]       tr_match;
  logic [CFG_W-1:0] max_body_cfg;

  result_word_t     pending_results [$];
  stim_row_t        word_q [$];
  logic [CFG_W-1:0] limit_now = MAX_BODY_RESET;
  bit               start_next = 1'b0;
  int               burst_left = 0;
  int               words_sent = 0;
  int               err_count = 0;
  int               stuck_cycles = 0;
  logic [15:0]      stall_pat = 16'hFFFF;
  logic [7:0]       pat_step = '0;

  chunked_body_decoder_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .new_body     (new_body),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // CR LF closed the size line: zero size opens the trailer, else data
  function automatic void close_size_line();
    if (chunk_left == '0) begin
      ps = PH_TR_FIRST;
    end else begin
      body_sum = body_sum + chunk_left;
      ps = PH_DATA;
    end
  endfunction

  // Decode one byte; has is set when the byte yields a result word
  function automatic void decode_step(input logic [7:0] b, input logic s,
                                      output bit has, output result_word_t res);
    int d;
    longint unsigned nxt;
    longint unsigned lim;
    bit bad;
    bit done;
    logic [7:0] want_ch;
    lim = (64'(max_body_cfg) < LEN_MASK) ? 64'(max_body_cfg) : LEN_MASK;
    has = 1'b0;
    bad = 1'b0;
    done = 1'b0;
    res = '0;
    if (s) begin
      ps = PH_SIZE;
      chunk_left = '0;
      body_sum = '0;
      too_large = 1'b0;
      has_digit = 1'b0;
      tr_match = '0;
    end
    case (ps)
      PH_SIZE: begin
        d = hex_val(b);
        if (d >= 0) begin
          nxt = 64'(chunk_left) * 64'd16 + 64'(d);
          if (nxt + 64'(body_sum) > lim) begin
            too_large = 1'b1;
            bad = 1'b1;
          end else begin
            chunk_left = 26'(nxt);
            has_digit = 1'b1;
          end
        end else if (!has_digit) begin
          bad = 1'b1;
        end else if (b == CHAR_SEMI) begin
          ps = PH_EXT;
        end else if (b == CHAR_CR) begin
          ps = PH_SIZE_LF;
        end else begin
          bad = 1'b1;
        end
      end
      PH_SIZE_LF: begin
        if (b != CHAR_LF) bad = 1'b1;
        else close_size_line();
      end
      PH_EXT: begin
        if (b == CHAR_CR) ps = PH_EXT_LF;
      end
      PH_EXT_LF: begin
        if (b == CHAR_LF) close_size_line();
        else if (b != CHAR_CR) ps = PH_EXT;
      end
      PH_DATA: begin
        chunk_left = chunk_left - 26'd1;
        if (chunk_left == '0) ps = PH_DATA_CR;
        has = 1'b1;
        res.kind = KIND_PAYLOAD;
        res.pbyte = b;
      end
      PH_DATA_CR: begin
        if (b != CHAR_CR) bad = 1'b1;
        else ps = PH_DATA_LF;
      end
      PH_DATA_LF: begin
        if (b != CHAR_LF) begin
          bad = 1'b1;
        end else begin
          ps = PH_SIZE;
          chunk_left = '0;
          has_digit = 1'b0;
        end
      end
      PH_TR_FIRST: begin
        if (b == CHAR_CR) begin
          ps = PH_TR_FIRST_LF;
        end else begin
          tr_match = '0;
          ps = PH_TRAILER;
        end
      end
      PH_TR_FIRST_LF: begin
        if (b == CHAR_LF) begin
          done = 1'b1;
        end else begin
          tr_match = (b == CHAR_CR) ? 2'd1 : 2'd0;
          ps = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        // hunt for CR LF CR LF
        want_ch = tr_match[0] ? CHAR_LF : CHAR_CR;
        if (b == want_ch) begin
          if (tr_match == 2'd3) begin
            tr_match = '0;
            done = 1'b1;
          end else begin
            tr_match = tr_match + 2'd1;
          end
        end else begin
          tr_match = (b == CHAR_CR) ? 2'd1 : 2'd0;
        end
      end
      default: ;
    endcase
    if (bad) begin
      ps = PH_FAIL;
      has = 1'b1;
      res.kind = KIND_BAD;
    end else if (done) begin
      ps = PH_DONE;
      has = 1'b1;
      res.kind = KIND_DONE;
    end
  endfunction

  // Scoreboard: check output words, then predict from accepted input words
  always @(posedge clk) begin : score
    result_word_t want;
    result_word_t got;
    bit has;
    if (rst) begin
      ps = PH_IDLE;
      chunk_left = '0;
      body_sum = '0;
      too_large = 1'b0;
      has_digit = 1'b0;
      tr_match = '0;
      max_body_cfg = MAX_BODY_RESET;
      pending_results.delete();
    end else begin
      got.kind = result_kind;
      got.pbyte = payload_byte;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("unexpected result: kind %0d byte %02h",
                               got.kind, got.pbyte));
        end else begin
          want = pending_results.pop_front();
          if (want.kind != got.kind || want.pbyte != got.pbyte)
            flag_error($sformatf("mismatch: expected kind %0d byte %02h, got kind %0d byte %02h",
                                 want.kind, want.pbyte, got.kind, got.pbyte));
        end
      end
      if (cfg_valid && cfg_ready) max_body_cfg = cfg_data;
      if (in_valid && in_ready) begin
        decode_step(data_byte, new_body, has, want);
        if (tag_mode == CHK_NONE) begin
          has = 1'b0;
        end else if (tag_mode == CHK_WORD) begin
          has = 1'b1;
          want.kind = tag_kind;
          want.pbyte = tag_byte;
        end
        if (has) pending_results.push_back(want);
      end
    end
  end

  // Receiver stall pattern, reshuffled each time the low six bits of pat_step reach all ones
  always @(posedge clk) begin
    pat_step <= pat_step + 8'd1;
    if (pat_step[5:0] == 6'd63) begin
      case ($urandom_range(0, 3))
        0: stall_pat <= 16'hFFFF;
        1: stall_pat <= 16'($urandom) | 16'h0001;
        2: stall_pat <= 16'($urandom | $urandom) | 16'h0001;
        default: stall_pat <= 16'($urandom & $urandom) | 16'h0001;
      endcase
    end
    out_ready <= stall_pat[pat_step[3:0]];
  end

  // Watchdog: too long without any word moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Offer one word; sender runs in bursts with gaps between them
  task automatic send_row(input stim_row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    data_byte <= r.data;
    new_body <= r.start;
    tag_mode <= r.mode;
    tag_kind <= r.kind;
    tag_byte <= r.pbyte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // Stop sending and wait until every expected word is out
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_body(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    limit_now = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b);
    stim_row_t r;
    r = '{b, start_next, CHK_MODEL, KIND_PAYLOAD, 8'h00};
    start_next = 1'b0;
    word_q.push_back(r);
  endtask

  // Hex digits of v, mixed case, sometimes with leading zeros
  task automatic put_hex(input logic [CFG_W-1:0] v);
    int nd;
    int i;
    logic [3:0] nib;
    nd = 1;
    while (nd < 7 && (v >> (4 * nd)) != '0) nd++;
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) push_byte("0");
    for (i = nd - 1; i >= 0; i--) begin
      nib = 4'(v >> (4 * i));
      if (nib < 4'd10) push_byte("0" + 8'(nib));
      else if ($urandom_range(0, 1) == 1) push_byte("A" + 8'(nib - 4'd10));
      else push_byte("a" + 8'(nib - 4'd10));
    end
  endtask

  task automatic put_size_line(input logic [CFG_W-1:0] v);
    put_hex(v);
    if ($urandom_range(0, 3) == 0) begin
      push_byte(CHAR_SEMI);
      repeat ($urandom_range(0, 5)) push_byte(8'($urandom));
    end
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
  endtask

  // Build one body into word_q; unless clean, it may be broken or preceded by strays
  task automatic gen_body(input bit clean);
    int b0;
    int sz;
    int p;
    logic [CFG_W-1:0] probe;
    stim_row_t r;
    if (!clean && $urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
    b0 = word_q.size();
    start_next = 1'b1;
    if (!clean && $urandom_range(0, 9) == 0) begin
      // size at or just past the limit, or random, then a few data bytes, left open
      case ($urandom_range(0, 2))
        0: probe = limit_now;
        1: probe = limit_now + CFG_W'(1);
        default: probe = CFG_W'($urandom);
      endcase
      put_hex(probe);
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 3)) begin
        sz = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        put_size_line(CFG_W'(sz));
        repeat (sz) push_byte(8'($urandom));
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
      end
      put_size_line('0);
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 2)) begin
          repeat ($urandom_range(1, 10))
            push_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126)));
          push_byte(CHAR_CR);
          push_byte(CHAR_LF);
        end
      end
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
      if (!clean) begin
        p = $urandom_range(b0 + 1, word_q.size() - 1);
        case ($urandom_range(0, 4))
          0, 1: begin
            r = word_q[p];
            r.data = 8'($urandom);
            word_q[p] = r;
          end
          2: word_q.delete(p);
          3: while (word_q.size() > p) word_q.delete(word_q.size() - 1);
          default: ;
        endcase
      end
    end
  endtask

  task automatic drain_words();
    while (word_q.size() != 0) begin
      send_row(word_q.pop_front());
      words_sent++;
    end
  endtask

  initial begin
    int i;
    int ph;
    int goal;
    logic [CFG_W-1:0] phase_limit [5];
    int phase_words [5];

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed words, limit at reset value then zero
    for (i = 0; i < 29; i++) begin
      if (i == DIRECTED_CFG_AT) begin
        wait_quiet();
        write_max_body('0);
      end
      send_row(DIRECTED[i]);
    end
    wait_quiet();

    // random bodies over several limits
    phase_limit[0] = MAX_BODY_RESET;
    phase_limit[1] = '0;
    phase_limit[2] = CFG_W'($urandom_range(1, 64));
    phase_limit[3] = CFG_W'($urandom_range(0, MAX_BODY_RESET));
    phase_limit[4] = CFG_W'(1);
    phase_words = '{220, 40, 190, 180, 140};
    goal = 0;
    for (ph = 0; ph < 5; ph++) begin
      write_max_body(phase_limit[ph]);
      goal += phase_words[ph];
      while (words_sent < goal) begin
        gen_body($urandom_range(0, 9) < 6);
        drain_words();
      end
      // finish on a complete body so the limit changes with no body open
      gen_body(1'b1);
      drain_words();
      wait_quiet();
    end

    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", pending_results.size()));
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
